/* rtl/q4dp_pkg.sv */
package q4dp_pkg;

	localparam logic [3:0]  NIB_OFFSET = 4'd8;
	localparam logic [4:0]  HEXP_ALL   = 5'h1F;
	localparam logic [7:0]  EXP_REBIAS = 8'd112;
	localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF    = 32'h7F80_0000;

	// Operation codes for the shared float unit.
	typedef enum logic [1:0] {
		OP_MUL = 2'b01,
		OP_ADD = 2'b10
	} fop_t;

	typedef struct packed {
		logic        start;
		fop_t        op;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	// Widen a half-precision scale, flushing subnormals to signed zero.
	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic       s;
		logic [4:0] e;
		logic [9:0] m;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		if (e == 5'd0)
			return {s, 31'd0};
		else if (e == HEXP_ALL)
			return (m == 10'd0) ? (POS_INF | {s, 31'd0}) : CANON_NAN;
		else
			return {s, {3'd0, e} + EXP_REBIAS, m, 13'd0};
	endfunction

	// Convert (nibble - 8) to a single-precision value; small, so a table.
	function automatic logic [31:0] nib_to_float(input logic [3:0] n);
		logic signed [4:0] v;
		logic        [3:0] mag;
		logic        [31:0] r;
		v   = $signed({1'b0, n}) - $signed({1'b0, NIB_OFFSET});
		mag = v[4] ? 4'(-v) : v[3:0];
		r   = 32'd0;
		if (mag >= 4'd8)
			r = {v[4], 8'd130, 23'd0};
		else if (mag >= 4'd4)
			r = {v[4], 8'd129, mag[1:0], 21'd0};
		else if (mag >= 4'd2)
			r = {v[4], 8'd128, mag[0], 22'd0};
		else if (mag == 4'd1)
			r = {v[4], 8'd127, 23'd0};
		return r;
	endfunction

endpackage

/* rtl/q4dp_fpu.sv */
module q4dp_fpu
	import q4dp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fpu_req_t    req,
	output logic        done,
	output logic [31:0] res
);

	// Float unit in stages: unpack/multiply or align, normalise, round.
	logic         v_s1, v_s2;
	logic         sp_s1;
	logic         spv_s1;
	logic [31:0]  spres_s1;
	logic         sgn_s1;
	logic signed [10:0] exp_s1;
	logic [49:0]  mag_s1;
	logic         sgn_s2;
	logic signed [10:0] exp_s2;
	logic [49:0]  mag_s2;
	logic         sp_s2;
	logic [31:0]  spres_s2;
	logic [31:0]  res_q;
	logic         done_q;

	logic         sa, sb;
	logic [7:0]   ea, eb;
	logic [22:0]  fa, fb;
	logic [23:0]  ma, mb;
	logic         ana, anb, aia, aib, aza, azb;
	logic signed [10:0] xa, xb;

	always_comb begin
		sa = req.a[31]; ea = req.a[30:23]; fa = req.a[22:0];
		sb = req.b[31]; eb = req.b[30:23]; fb = req.b[22:0];
		ma = {(ea != 8'd0), fa};
		mb = {(eb != 8'd0), fb};
		xa = (ea == 8'd0) ? 11'sd1 : $signed({3'd0, ea});
		xb = (eb == 8'd0) ? 11'sd1 : $signed({3'd0, eb});
		ana = (ea == 8'hFF) && (fa != 23'd0);
		anb = (eb == 8'hFF) && (fb != 23'd0);
		aia = (ea == 8'hFF) && (fa == 23'd0);
		aib = (eb == 8'hFF) && (fb == 23'd0);
		aza = (ea == 8'd0) && (fa == 23'd0);
		azb = (eb == 8'd0) && (fb == 23'd0);
	end

	// Stage 1: special values, product or aligned sum.
	logic [47:0]  prod;
	logic         big_a;
	logic [23:0]  mbig, msml;
	logic signed [10:0] xbig, xsml;
	logic         sbig, ssml;
	logic [10:0]  dsh;
	logic [49:0]  wbig, wsml, shifted;
	logic         sticky;
	logic         sp_c;
	logic [31:0]  spres_c;

	always_comb begin
		prod  = ma * mb;
		big_a = ({ea, fa} >= {eb, fb});
		mbig  = big_a ? ma : mb;  msml = big_a ? mb : ma;
		xbig  = big_a ? xa : xb;  xsml = big_a ? xb : xa;
		sbig  = big_a ? sa : sb;  ssml = big_a ? sb : sa;
		dsh   = 11'(xbig - xsml);
		wbig  = {1'b0, mbig, 25'd0};
		wsml  = {1'b0, msml, 25'd0};
		shifted = (dsh > 11'd49) ? 50'd0 : (wsml >> dsh);
		sticky  = (dsh > 11'd49) ? (msml != 24'd0)
			: ((wsml & ((50'd1 << dsh) - 50'd1)) != 50'd0);
	end

	always_comb begin
		sp_c    = 1'b0;
		spres_c = CANON_NAN;
		if (req.op == OP_MUL) begin
			if (ana || anb || (aia && azb) || (aib && aza)) begin
				sp_c = 1'b1;
			end else if (aia || aib) begin
				sp_c    = 1'b1;
				spres_c = {sa ^ sb, 8'hFF, 23'd0};
			end
		end else begin
			if (ana || anb || (aia && aib && (sa != sb))) begin
				sp_c = 1'b1;
			end else if (aia || aib) begin
				sp_c    = 1'b1;
				spres_c = aia ? req.a : req.b;
			end else if (aza && azb) begin
				sp_c    = 1'b1;
				spres_c = {sa & sb, 31'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		spv_s1   <= sp_c;
		spres_s1 <= spres_c;
		if (req.op == OP_MUL) begin
			sgn_s1 <= sa ^ sb;
			exp_s1 <= xa + xb - 11'sd124;
			mag_s1 <= {2'b0, prod};
		end else begin
			sgn_s1 <= sbig;
			exp_s1 <= xbig + 11'sd1;
			mag_s1 <= ((sbig == ssml) ? (wbig + shifted)
				: (wbig - shifted - {49'd0, sticky})) | {49'd0, sticky};
		end
	end
	assign sp_s1 = spv_s1;

	// Exact zero: product keeps sign, a cancelling sum gives +0.
	logic prodzero_sel;
	logic op_s1_mul;
	always_ff @(posedge clk) op_s1_mul <= (req.op == OP_MUL);
	assign prodzero_sel = op_s1_mul;

	// Stage 2: normalise so bit 49 leads; the biased exponent follows the shift.
	logic [5:0]   lz;
	logic [49:0]  nmag;
	logic signed [10:0] nexp;
	logic         nsp;
	logic [31:0]  nspres;
	always_comb begin
		lz = 6'd50;
		for (int i = 0; i < 50; i++)
			if (mag_s1[i]) lz = 6'(49 - i);
		nmag = mag_s1 << lz;
		nexp = exp_s1 - $signed({5'd0, lz});
		nsp  = sp_s1 || (mag_s1 == 50'd0);
		nspres = (!sp_s1 && (mag_s1 == 50'd0)) ? {sgn_s1 & prodzero_sel, 31'd0}
			: spres_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		sgn_s2   <= sgn_s1;
		sp_s2    <= nsp;
		spres_s2 <= nspres;
		exp_s2   <= nexp;
		mag_s2   <= nmag;
	end

	// Stage 3: denormalise if needed, round to nearest even, pack.
	logic [10:0]  rsh;
	logic [49:0]  dm;
	logic         dst;
	logic [23:0]  kept;
	logic         g, st, up;
	logic [24:0]  rnd;
	logic signed [10:0] fexp;
	logic [31:0]  packed_r;
	always_comb begin
		// mag_s2[49] is the leading bit; biased exponent is exp_s2.
		rsh = (exp_s2 < 11'sd1) ? 11'(11'sd1 - exp_s2) : 11'd0;
		dm  = (rsh > 11'd49) ? 50'd0 : (mag_s2 >> rsh);
		dst = (rsh > 11'd49) ? 1'b1 : ((mag_s2 & ((50'd1 << rsh) - 50'd1)) != 50'd0);
		kept = dm[49:26];
		g    = dm[25];
		st   = (dm[24:0] != 25'd0) || dst;
		up   = g && (st || kept[0]);
		rnd  = {1'b0, kept} + {24'd0, up};
		fexp = (exp_s2 < 11'sd1) ? 11'sd0 : exp_s2;
		if (rnd[24]) begin
			fexp = fexp + 11'sd1;
			rnd  = rnd >> 1;
		end else if (fexp == 11'sd0 && rnd[23]) begin
			fexp = 11'sd1;
		end
		if (fexp >= 11'sd255)
			packed_r = {sgn_s2, 8'hFF, 23'd0};
		else
			packed_r = {sgn_s2, fexp[7:0], rnd[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v_s2;
	end

	always_ff @(posedge clk) res_q <= sp_s2 ? spres_s2 : packed_r;

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/q4_0_row_dot_product.sv */
// Each word steps through ST_WLO, ST_PLO, ST_ALO, ST_WHI, ST_PHI and ST_AHI; a
// row's last word then goes to ST_EMIT. A new word is taken only in ST_IDLE, not
// before the previous one is through, and after a row's end not while the previous
// result word still waits. The shared three-stage float unit runs six dependent
// ops per word (two weight and two activation multiplies, two accumulates).
// Reset: arst_n clears the sequencer, the output valid flag and the running sum.
module q4_0_row_dot_product
	import q4dp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  quant_byte,
	input  logic [15:0] scale_half,
	input  logic [31:0] act_low,
	input  logic [31:0] act_high,
	input  logic        last_pair,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] dot_value
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_WLO   = 8'b0000_0010,
		ST_PLO   = 8'b0000_0100,
		ST_ALO   = 8'b0000_1000,
		ST_WHI   = 8'b0001_0000,
		ST_PHI   = 8'b0010_0000,
		ST_AHI   = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic        busy_q;
	logic [31:0] scale_q, act_lo_q, act_hi_q, sum_q, tmp_q, out_q;
	logic [7:0]  byte_q;
	logic        last_q, ov_q;
	fpu_req_t    req;
	logic        done;
	logic [31:0] res;

	// The unit is started once on entry to each step; busy_q marks a pending op.
	q4dp_fpu u_fpu (.clk(clk), .arst_n(arst_n), .req(req), .done(done), .res(res));

	// The output register parts the two sides: a new word may be taken while the
	// previous result word still waits; the finished sum then waits in ST_EMIT.
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign dot_value = out_q;

	always_comb begin
		req.start = 1'b0;
		req.op    = OP_MUL;
		req.a     = scale_q;
		req.b     = nib_to_float(byte_q[3:0]);
		if (!busy_q) begin
			unique case (state_q)
				ST_WLO: begin req.start = 1'b1; end
				ST_PLO: begin req.start = 1'b1; req.a = tmp_q; req.b = act_lo_q; end
				ST_ALO: begin req.start = 1'b1; req.op = OP_ADD; req.a = sum_q; req.b = tmp_q; end
				ST_WHI: begin req.start = 1'b1; req.b = nib_to_float(byte_q[7:4]); end
				ST_PHI: begin req.start = 1'b1; req.a = tmp_q; req.b = act_hi_q; end
				ST_AHI: begin req.start = 1'b1; req.op = OP_ADD; req.a = sum_q; req.b = tmp_q; end
				default: ;
			endcase
		end else begin
			unique case (state_q)
				ST_ALO, ST_AHI: req.op = OP_ADD;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			ov_q    <= 1'b0;
			sum_q   <= 32'd0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (req.start) busy_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_WLO;
				ST_WLO, ST_PLO, ST_WHI, ST_PHI: if (done) begin
					busy_q <= 1'b0;
					tmp_q  <= res;
					state_q <= state_t'(state_q << 1);
				end
				ST_ALO: if (done) begin
					busy_q <= 1'b0; sum_q <= res; state_q <= ST_WHI;
				end
				ST_AHI: if (done) begin
					busy_q <= 1'b0;
					if (last_q) begin
						sum_q <= 32'd0;
						tmp_q <= ((res[30:23] == 8'hFF) && (res[22:0] != 23'd0))
							? CANON_NAN : res;
						state_q <= ST_EMIT;
					end else begin
						sum_q <= res;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: if (!ov_q) begin
					out_q   <= tmp_q;
					ov_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			scale_q  <= widen_half(scale_half);
			byte_q   <= quant_byte;
			act_lo_q <= act_low;
			act_hi_q <= act_high;
			last_q   <= last_pair;
		end
	end

endmodule
